/* hdl/hrcp_pkg.sv */
// package: types, constants and helper functions of the response header and chunk parser
`default_nettype none
package hrcp_pkg;

  localparam int SIZE_BITS = 32;
  localparam int CL_W = (SIZE_BITS < 32) ? SIZE_BITS : 32;
  localparam int NAME_LEN = 14;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_SIZE = 3'd1;
  localparam logic [2:0] PH_PAY  = 3'd2;
  localparam logic [2:0] PH_TRL  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  localparam logic [3:0] KIND_NAME     = 4'd0;
  localparam logic [3:0] KIND_COLON    = 4'd1;
  localparam logic [3:0] KIND_VALUE    = 4'd2;
  localparam logic [3:0] KIND_LINE_END = 4'd3;
  localparam logic [3:0] KIND_HDR_END  = 4'd4;
  localparam logic [3:0] KIND_SIZE     = 4'd5;
  localparam logic [3:0] KIND_PAYLOAD  = 4'd6;
  localparam logic [3:0] KIND_TRAILER  = 4'd7;
  localparam logic [3:0] KIND_BODY_END = 4'd8;
  localparam logic [3:0] KIND_IGNORED  = 4'd9;

  localparam logic [1:0] VAL_SKIP    = 2'd0;
  localparam logic [1:0] VAL_DIGITS  = 2'd1;
  localparam logic [1:0] VAL_STOPPED = 2'd2;

  typedef struct packed {
    logic [2:0]           phase;
    logic                 prev_cr;
    logic                 colon_seen;
    logic                 line_empty;
    logic [3:0]           name_index;
    logic                 name_match;
    logic [31:0]          length;
    logic                 hex_ended;
    logic [SIZE_BITS-1:0] size;
    logic [SIZE_BITS-1:0] left;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:      PH_HDR,
    prev_cr:    1'b0,
    colon_seen: 1'b0,
    line_empty: 1'b1,
    name_index: 4'd0,
    name_match: 1'b1,
    length:     32'd0,
    hex_ended:  1'b0,
    size:       '0,
    left:       '0
  };

  typedef struct packed {
    logic [7:0]  data;
    logic [3:0]  kind;
    logic [31:0] content_length;
    logic [31:0] chunk_length;
    logic        done;
  } result_t;

  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h4C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // msb flags a hex digit, low four bits give its value
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    logic [7:0] t;
    r = 5'd0;
    t = 8'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      t = b - 8'h30;
      r = {1'b1, t[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      t = b - 8'h57;
      r = {1'b1, t[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      t = b - 8'h37;
      r = {1'b1, t[3:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/http_response_header_chunk_parser.sv */
// top level: input register, parser core and result register
// Tags an HTTP/1.1 response one byte per cycle unless out_stall holds it: header names,
// colons, values, line ends, the end of the headers (the body end if Content-Length is
// nonzero), else chunked size lines, payload and trailer bytes to the end of the body.
// Content-Length and the current chunk size travel with every item. Each byte passes
// the input register, then the result register; the parser state updates once per
// accepted byte, so one item is accepted every cycle while the result side keeps up.
`default_nettype none
module http_response_header_chunk_parser (
  input  var logic        clk,
  input  var logic        rst_n,
  input  var logic        in_valid,
  output logic            in_stall,
  input  var logic [7:0]  in_byte_in,
  output logic            out_valid,
  input  var logic        out_stall,
  output logic [7:0]      out_byte_out,
  output logic [3:0]      out_kind,
  output logic [31:0]     out_content_length,
  output logic [31:0]     out_chunk_length,
  output logic            out_body_done
);
  import hrcp_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    core_res;
  logic [2:0] core_phase;
  logic       advance;
  logic       step_en;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign step_en  = s1_valid_r && advance;

  hrcp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .b       (s1_byte_r),
    .res     (core_res),
    .phase   (core_phase)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_out       = out_res_r.data;
  assign out_kind           = out_res_r.kind;
  assign out_content_length = out_res_r.content_length;
  assign out_chunk_length   = out_res_r.chunk_length;
  assign out_body_done      = out_res_r.done;

  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.done |->
      (out_res_r.kind == KIND_HDR_END) || (out_res_r.kind == KIND_BODY_END))
    else $error("body done on a byte that is not a line end");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.done |-> (core_phase == PH_DONE))
    else $error("parser left the done phase after the body ended");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted item lost at the input register");

  a_ignored_after: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (core_phase == PH_DONE) |=> (out_res_r.kind == KIND_IGNORED))
    else $error("byte after the end not tagged as ignored");

endmodule
`default_nettype wire

/* hdl/hrcp_hdr.sv */
// header line logic: name match, colon split, content length digits, line ends
`default_nettype none
module hrcp_hdr (
  input  var hrcp_pkg::state_t st,
  input  var logic [7:0]       b,
  output hrcp_pkg::state_t     st_nxt,
  output logic [3:0]           kind,
  output logic                 done
);
  import hrcp_pkg::*;

  logic        crlf;
  logic [3:0]  digit;
  logic [7:0]  digit_w;
  logic [35:0] len_prod;
  logic        is_digit;

  assign crlf     = (b == CH_CR) || (b == CH_LF);
  assign is_digit = (b >= 8'h30) && (b <= 8'h39);
  assign digit_w  = b - 8'h30;
  assign digit    = digit_w[3:0];
  assign len_prod = {1'b0, st.length, 3'b000} + {3'b000, st.length, 1'b0}
                    + {32'd0, digit};

  always_comb begin
    st_nxt = st;
    kind   = KIND_NAME;
    done   = 1'b0;
    if (b == CH_LF && st.prev_cr) begin
      st_nxt.prev_cr = 1'b0;
      if (st.line_empty) begin
        kind = KIND_HDR_END;
        if (st.length != 32'd0) begin
          st_nxt.phase = PH_DONE;
          done         = 1'b1;
        end else begin
          st_nxt.phase     = PH_SIZE;
          st_nxt.size      = '0;
          st_nxt.hex_ended = 1'b0;
        end
      end else begin
        kind              = KIND_LINE_END;
        st_nxt.colon_seen = 1'b0;
        st_nxt.line_empty = 1'b1;
        st_nxt.name_index = 4'd0;
        st_nxt.name_match = 1'b1;
      end
    end else begin
      if (!st.colon_seen) begin
        if (b == CH_COLON) begin
          kind              = KIND_COLON;
          st_nxt.colon_seen = 1'b1;
          if (st.name_match && st.name_index == 4'(NAME_LEN)) begin
            st_nxt.length     = 32'd0;
            st_nxt.name_index = 4'd0;
          end else begin
            st_nxt.name_match = 1'b0;
          end
        end else begin
          kind = crlf ? KIND_LINE_END : KIND_NAME;
          if (st.name_match && st.name_index < 4'(NAME_LEN)
              && b == name_char(st.name_index)) begin
            st_nxt.name_index = st.name_index + 4'd1;
          end else begin
            st_nxt.name_match = 1'b0;
          end
        end
      end else begin
        kind = crlf ? KIND_LINE_END : KIND_VALUE;
        if (st.name_match) begin
          if (st.name_index == 4'(VAL_SKIP) && b == CH_SPACE) begin
            st_nxt.name_index = st.name_index;
          end else if (st.name_index < 4'(VAL_STOPPED) && is_digit) begin
            st_nxt.name_index = 4'(VAL_DIGITS);
            if (len_prod[35:32] != 4'd0) begin
              st_nxt.length = 32'hFFFF_FFFF;
            end else begin
              st_nxt.length = len_prod[31:0];
            end
          end else begin
            st_nxt.name_index = 4'(VAL_STOPPED);
          end
        end
      end
      st_nxt.line_empty = st.line_empty && (b == CH_CR) && !st.prev_cr;
      st_nxt.prev_cr    = (b == CH_CR);
    end
  end

endmodule
`default_nettype wire

/* hdl/hrcp_core.sv */
// parser state register and per-byte next-state logic for all phases
`default_nettype none
module hrcp_core (
  input  var logic              clk,
  input  var logic              rst_n,
  input  var logic              step_en,
  input  var logic [7:0]        b,
  output hrcp_pkg::result_t     res,
  output logic [2:0]            phase
);
  import hrcp_pkg::*;

  state_t               st_r;
  state_t               st_nxt;
  state_t               hdr_st;
  logic   [3:0]         hdr_kind;
  logic                 hdr_done;
  logic   [3:0]         kind;
  logic                 done;
  logic   [4:0]         hx;
  logic   [SIZE_BITS+3:0] size_prod;
  logic   [SIZE_BITS-1:0] left_dec;

  hrcp_hdr u_hdr (
    .st     (st_r),
    .b      (b),
    .st_nxt (hdr_st),
    .kind   (hdr_kind),
    .done   (hdr_done)
  );

  assign hx        = hex_val(b);
  assign size_prod = {st_r.size, 4'b0000} | {{SIZE_BITS{1'b0}}, hx[3:0]};
  assign left_dec  = (st_r.left != '0) ? st_r.left - SIZE_BITS'(1) : st_r.left;

  always_comb begin
    st_nxt = st_r;
    kind   = KIND_IGNORED;
    done   = 1'b0;
    case (st_r.phase)
      PH_HDR: begin
        st_nxt = hdr_st;
        kind   = hdr_kind;
        done   = hdr_done;
      end
      PH_SIZE: begin
        kind = KIND_SIZE;
        if (b == CH_LF && st_r.prev_cr) begin
          st_nxt.prev_cr = 1'b0;
          if (st_r.size == '0) begin
            kind         = KIND_BODY_END;
            done         = 1'b1;
            st_nxt.phase = PH_DONE;
          end else begin
            st_nxt.left  = st_r.size;
            st_nxt.phase = PH_PAY;
          end
        end else begin
          if (hx[4] && !st_r.hex_ended) begin
            if (size_prod[SIZE_BITS+3:SIZE_BITS] != 4'd0) begin
              st_nxt.size = '1;
            end else begin
              st_nxt.size = size_prod[SIZE_BITS-1:0];
            end
          end else begin
            st_nxt.hex_ended = 1'b1;
          end
          st_nxt.prev_cr = (b == CH_CR);
        end
      end
      PH_PAY: begin
        kind = KIND_PAYLOAD;
        if (left_dec == '0) begin
          st_nxt.phase = PH_TRL;
          st_nxt.left  = SIZE_BITS'(2);
        end else begin
          st_nxt.left = left_dec;
        end
      end
      PH_TRL: begin
        kind        = KIND_TRAILER;
        st_nxt.left = left_dec;
        if (left_dec == '0) begin
          st_nxt.phase     = PH_SIZE;
          st_nxt.size      = '0;
          st_nxt.hex_ended = 1'b0;
          st_nxt.prev_cr   = 1'b0;
        end
      end
      default: begin
        kind = KIND_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

  assign res.data           = b;
  assign res.kind           = kind;
  assign res.content_length = st_nxt.length;
  assign res.chunk_length   = 32'(st_nxt.size[CL_W-1:0]);
  assign res.done           = done;
  assign phase              = st_r.phase;

endmodule
`default_nettype wire
